// ===== rtl/pfa_pkg.sv =====
// Shared types and constants for the packet frame accounting block.
package pfa_pkg;

   localparam int unsigned WordCountWidth = 14;
   localparam int unsigned DataWidth      = 32;
   localparam int unsigned EventWidth     = 16;
   localparam int unsigned LimitWidth     = 16;
   localparam int unsigned ByteWidth      = WordCountWidth + 2;
   localparam int unsigned SegByteWidth   = 40;
   localparam int unsigned MbShift        = 20;
   localparam int unsigned CsrIndexWidth  = 2;

   localparam logic [SegByteWidth-1:0] SegPad = SegByteWidth'(1008);

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_START_MARKER  = 2'd0,
      CSR_END_MARKER    = 2'd1,
      CSR_SEGMENT_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DataWidth-1:0]  start_marker;
      logic [DataWidth-1:0]  end_marker;
      logic [LimitWidth-1:0] segment_limit_mb;
   } config_type;

   typedef struct packed {
      logic [WordCountWidth-1:0] word_count;
      logic [DataWidth-1:0]      counter_word;
      logic [DataWidth-1:0]      marker_word;
      logic [DataWidth-1:0]      frame_word;
      logic [DataWidth-1:0]      tail_word;
      logic [DataWidth-1:0]      lost_word;
      logic [DataWidth-1:0]      buffer_run;
   } item_type;

   typedef struct packed {
      logic [DataWidth-1:0]  file_run;
      logic [DataWidth-1:0]  segment_index;
      logic                  segment_closed;
      logic                  frame_done;
      logic                  no_start_error;
      logic [DataWidth-1:0]  frame_number;
      logic [DataWidth-1:0]  packet_total;
      logic [EventWidth-1:0] event_total;
      logic [EventWidth-1:0] lost_events;
      logic [DataWidth-1:0]  missed_packets;
      logic [DataWidth-1:0]  frames_lost;
      logic [DataWidth-1:0]  frame_bytes;
   } result_type;

endpackage

// ===== rtl/pfa_in_stage.sv =====
// Input register for packet summaries.
module pfa_in_stage
   import pfa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  item_type req_item,
   output logic     req_ready,
   input  logic     advance,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_ready  = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== rtl/pfa_account.sv =====
// Frame and segment accounting state with the per-packet result logic.
module pfa_account
   import pfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  config_type cfg,
   input  logic       advance,
   input  item_type   item,
   output result_type result
);

   logic                    frame_started_ff, frame_started_in;
   logic [DataWidth-1:0]    current_frame_ff, current_frame_in;
   logic [DataWidth-1:0]    previous_frame_ff, previous_frame_in;
   logic                    first_pending_ff, first_pending_in;
   logic [DataWidth-1:0]    first_counter_ff, first_counter_in;
   logic [DataWidth-1:0]    packet_tally_ff, packet_tally_in;
   logic [EventWidth-1:0]   event_tally_ff, event_tally_in;
   logic [DataWidth-1:0]    byte_tally_ff, byte_tally_in;
   logic [SegByteWidth-1:0] pad_bytes_ff, pad_bytes_in;
   logic [DataWidth-1:0]    segment_count_ff, segment_count_in;
   logic                    segment_open_ff, segment_open_in;
   logic [DataWidth-1:0]    segment_run_ff, segment_run_in;
   logic [DataWidth-1:0]    open_index_ff, open_index_in;

   logic                    is_start;
   logic                    is_end;
   logic                    closed;
   logic [ByteWidth-1:0]    bytes;
   logic [EventWidth-1:0]   payload;
   logic [DataWidth-1:0]    run;
   logic [DataWidth-1:0]    count_base;
   logic [DataWidth-1:0]    count_next;
   logic [SegByteWidth-1:0] pad_sum;
   logic [DataWidth-1:0]    packet_sum;
   logic [DataWidth-1:0]    byte_sum;
   logic [EventWidth-1:0]   event_sum;

   always_comb begin
      bytes      = {item.word_count, 2'b00};
      is_start   = item.marker_word == cfg.start_marker;
      is_end     = !is_start && (item.tail_word == cfg.end_marker);
      payload    = (is_start || is_end) ? EventWidth'(item.word_count) - EventWidth'(4)
                                        : EventWidth'(item.word_count) - EventWidth'(2);
      run        = is_start ? item.frame_word : item.buffer_run;
      count_base = is_start ? '0 : segment_count_ff;
      count_next = count_base + DataWidth'(1);
      pad_sum    = (is_start ? SegPad : pad_bytes_ff) + SegByteWidth'(bytes);
      closed     = pad_sum[SegByteWidth-1:MbShift] >
                   (SegByteWidth-MbShift)'(cfg.segment_limit_mb);
      packet_sum = packet_tally_ff + DataWidth'(1);
      byte_sum   = byte_tally_ff + DataWidth'(bytes);
      event_sum  = event_tally_ff + EventWidth'(payload[EventWidth-1:1]);
   end

   always_comb begin
      result                = '0;
      result.file_run       = segment_open_ff ? segment_run_ff : run;
      result.segment_index  = segment_open_ff ? open_index_ff : count_base;
      result.segment_closed = closed;
      result.frame_done     = is_end;
      result.no_start_error = !is_start && !frame_started_ff;
      if (is_end) begin
         result.frame_number   = current_frame_ff;
         result.packet_total   = packet_sum;
         result.event_total    = event_sum;
         result.lost_events    = item.lost_word[EventWidth-1:0];
         result.missed_packets = item.counter_word - first_counter_ff - packet_tally_ff;
         result.frames_lost    = first_pending_ff ? '0
                               : current_frame_ff - previous_frame_ff - DataWidth'(1);
         result.frame_bytes    = byte_sum;
      end
   end

   always_comb begin
      frame_started_in  = is_start ? 1'b1 : (is_end ? 1'b0 : frame_started_ff);
      current_frame_in  = is_start ? item.frame_word : current_frame_ff;
      first_counter_in  = is_start ? item.counter_word : first_counter_ff;
      previous_frame_in = is_end ? current_frame_ff : previous_frame_ff;
      first_pending_in  = is_end ? 1'b0 : first_pending_ff;
      packet_tally_in   = is_end ? '0 : packet_sum;
      byte_tally_in     = is_end ? '0 : byte_sum;
      event_tally_in    = is_end ? '0 : event_sum;
      segment_open_in   = !is_end;
      pad_bytes_in      = (closed || is_end) ? SegPad : pad_sum;
      segment_run_in    = (closed || !segment_open_ff) ? run : segment_run_ff;
      priority if (is_end) begin
         segment_count_in = '0;
      end else if (closed) begin
         segment_count_in = count_next;
      end else begin
         segment_count_in = count_base;
      end
      priority if (closed) begin
         open_index_in = count_next;
      end else if (!segment_open_ff) begin
         open_index_in = count_base;
      end else begin
         open_index_in = open_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_started_ff  <= 1'b0;
         current_frame_ff  <= '0;
         previous_frame_ff <= '0;
         first_pending_ff  <= 1'b1;
         first_counter_ff  <= '0;
         packet_tally_ff   <= '0;
         event_tally_ff    <= '0;
         byte_tally_ff     <= '0;
         pad_bytes_ff      <= SegPad;
         segment_count_ff  <= '0;
         segment_open_ff   <= 1'b0;
         segment_run_ff    <= '0;
         open_index_ff     <= '0;
      end else if (advance) begin
         frame_started_ff  <= frame_started_in;
         current_frame_ff  <= current_frame_in;
         previous_frame_ff <= previous_frame_in;
         first_pending_ff  <= first_pending_in;
         first_counter_ff  <= first_counter_in;
         packet_tally_ff   <= packet_tally_in;
         event_tally_ff    <= event_tally_in;
         byte_tally_ff     <= byte_tally_in;
         pad_bytes_ff      <= pad_bytes_in;
         segment_count_ff  <= segment_count_in;
         segment_open_ff   <= segment_open_in;
         segment_run_ff    <= segment_run_in;
         open_index_ff     <= open_index_in;
      end
   end

   a_done_clears_frame: assert property (@(posedge clock) disable iff (reset)
      advance && result.frame_done |=> !frame_started_ff && packet_tally_ff == '0)
      else $error("frame end did not clear frame state");

   a_done_closes_segment: assert property (@(posedge clock) disable iff (reset)
      advance && result.frame_done |=> !segment_open_ff && segment_count_ff == '0)
      else $error("frame end did not close segment");

   a_close_rearms_bytes: assert property (@(posedge clock) disable iff (reset)
      advance && result.segment_closed |=> pad_bytes_ff == SegPad)
      else $error("segment close did not rearm byte count");

   a_pad_floor: assert property (@(posedge clock) disable iff (reset)
      pad_bytes_ff >= SegPad)
      else $error("segment byte count lost its pad");

endmodule

// ===== rtl/pfa_out_stage.sv =====
// Result register toward the receiver.
module pfa_out_stage
   import pfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       out_free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign out_free   = !valid_ff || rsp_ready;
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      valid_in = valid_ff;
      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

endmodule

// ===== rtl/packet_frame_accounting.sv =====
// Packet frame accounting top level: one result per packet summary.
//
// req channel: one packet summary per transfer (valid/ready).
// rsp channel: one result per packet, in order (valid/ready).
// csr port: write enable, index and data; start marker, end marker and
// segment limit in megabytes. Write only while no packet is in flight.
// A packet passes an input register, then the accounting logic updates the
// frame and segment state and loads the result register on the same edge.
// A req transfer is loaded into the input register and then into the result
// register, whose output is rsp valid. Throughput is one packet per cycle
// while the receiver does not stall, set by the single accounting pass
// between the two registers.
// When the receiver stalls, the result register holds, the input register
// fills and then req_ready drops; nothing is dropped.
// Reset (synchronous, active high) empties both registers, clears the
// markers and the limit to zero and returns the accounting state to its
// initial values (first frame pending, no segment open).
module packet_frame_accounting
   import pfa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CsrIndexWidth-1:0]  csr_index,
   input  logic [DataWidth-1:0]      csr_write_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [WordCountWidth-1:0] req_word_count,
   input  logic [DataWidth-1:0]      req_counter_word,
   input  logic [DataWidth-1:0]      req_marker_word,
   input  logic [DataWidth-1:0]      req_frame_word,
   input  logic [DataWidth-1:0]      req_tail_word,
   input  logic [DataWidth-1:0]      req_lost_word,
   input  logic [DataWidth-1:0]      req_buffer_run,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [DataWidth-1:0]      rsp_file_run,
   output logic [DataWidth-1:0]      rsp_segment_index,
   output logic                      rsp_segment_closed,
   output logic                      rsp_frame_done,
   output logic                      rsp_no_start_error,
   output logic [DataWidth-1:0]      rsp_frame_number,
   output logic [DataWidth-1:0]      rsp_packet_total,
   output logic [EventWidth-1:0]     rsp_event_total,
   output logic [EventWidth-1:0]     rsp_lost_events,
   output logic [DataWidth-1:0]      rsp_missed_packets,
   output logic [DataWidth-1:0]      rsp_frames_lost,
   output logic [DataWidth-1:0]      rsp_frame_bytes
);

   config_type cfg_ff;
   config_type cfg_in;
   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       out_free;
   logic       advance;
   result_type result;
   result_type rsp_result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_MARKER:  cfg_in.start_marker     = csr_write_data;
            CSR_END_MARKER:    cfg_in.end_marker       = csr_write_data;
            CSR_SEGMENT_LIMIT: cfg_in.segment_limit_mb = csr_write_data[LimitWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req_item.word_count   = req_word_count;
      req_item.counter_word = req_counter_word;
      req_item.marker_word  = req_marker_word;
      req_item.frame_word   = req_frame_word;
      req_item.tail_word    = req_tail_word;
      req_item.lost_word    = req_lost_word;
      req_item.buffer_run   = req_buffer_run;
   end

   assign advance = item_valid && out_free;

   pfa_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .req_ready  (req_ready),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   pfa_account u_account (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   pfa_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_file_run       = rsp_result.file_run;
   assign rsp_segment_index  = rsp_result.segment_index;
   assign rsp_segment_closed = rsp_result.segment_closed;
   assign rsp_frame_done     = rsp_result.frame_done;
   assign rsp_no_start_error = rsp_result.no_start_error;
   assign rsp_frame_number   = rsp_result.frame_number;
   assign rsp_packet_total   = rsp_result.packet_total;
   assign rsp_event_total    = rsp_result.event_total;
   assign rsp_lost_events    = rsp_result.lost_events;
   assign rsp_missed_packets = rsp_result.missed_packets;
   assign rsp_frames_lost    = rsp_result.frames_lost;
   assign rsp_frame_bytes    = rsp_result.frame_bytes;

endmodule

// ===== verif/tb_packet_frame_accounting.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for packet_frame_accounting: directed and random packet traffic.
module tb_packet_frame_accounting;
   import pfa_pkg::*;

   localparam int unsigned IdleLimit = 4000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   csr_index_type             csr_index = CSR_START_MARKER;
   logic [DataWidth-1:0]      csr_write_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   item_type                  req_item = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [DataWidth-1:0]      rsp_file_run;
   logic [DataWidth-1:0]      rsp_segment_index;
   logic                      rsp_segment_closed;
   logic                      rsp_frame_done;
   logic                      rsp_no_start_error;
   logic [DataWidth-1:0]      rsp_frame_number;
   logic [DataWidth-1:0]      rsp_packet_total;
   logic [EventWidth-1:0]     rsp_event_total;
   logic [EventWidth-1:0]     rsp_lost_events;
   logic [DataWidth-1:0]      rsp_missed_packets;
   logic [DataWidth-1:0]      rsp_frames_lost;
   logic [DataWidth-1:0]      rsp_frame_bytes;

   // accounting state mirrored by the predictor
   logic [DataWidth-1:0]  cfg_start_marker;
   logic [DataWidth-1:0]  cfg_end_marker;
   logic [LimitWidth-1:0] cfg_segment_limit;
   bit                    in_frame;
   logic [DataWidth-1:0]  frame_no;
   logic [DataWidth-1:0]  last_frame_no;
   bit                    awaiting_first_frame;
   logic [DataWidth-1:0]  frame_first_counter;
   logic [DataWidth-1:0]  frame_packets;
   logic [EventWidth-1:0] frame_events;
   logic [DataWidth-1:0]  frame_byte_sum;
   logic [63:0]           segment_fill;
   logic [DataWidth-1:0]  next_segment;
   bit                    file_open;
   logic [DataWidth-1:0]  file_run_no;
   logic [DataWidth-1:0]  file_segment_no;

   result_type packet_reports[$];

   int          error_count = 0;
   int          items_sent = 0;
   int          burst_left = 0;
   int          idle_cycles = 0;
   int          stall_mode = 0;
   int          stall_phase_left = 0;
   logic [31:0] gen_counter;
   logic [31:0] gen_frame_no;

   packet_frame_accounting DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_word_count     (req_item.word_count),
      .req_counter_word   (req_item.counter_word),
      .req_marker_word    (req_item.marker_word),
      .req_frame_word     (req_item.frame_word),
      .req_tail_word      (req_item.tail_word),
      .req_lost_word      (req_item.lost_word),
      .req_buffer_run     (req_item.buffer_run),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_file_run       (rsp_file_run),
      .rsp_segment_index  (rsp_segment_index),
      .rsp_segment_closed (rsp_segment_closed),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_no_start_error (rsp_no_start_error),
      .rsp_frame_number   (rsp_frame_number),
      .rsp_packet_total   (rsp_packet_total),
      .rsp_event_total    (rsp_event_total),
      .rsp_lost_events    (rsp_lost_events),
      .rsp_missed_packets (rsp_missed_packets),
      .rsp_frames_lost    (rsp_frames_lost),
      .rsp_frame_bytes    (rsp_frame_bytes)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic clear_model();
      cfg_start_marker     = '0;
      cfg_end_marker       = '0;
      cfg_segment_limit    = '0;
      in_frame             = 1'b0;
      frame_no             = '0;
      last_frame_no        = '0;
      awaiting_first_frame = 1'b1;
      frame_first_counter  = '0;
      frame_packets        = '0;
      frame_events         = '0;
      frame_byte_sum       = '0;
      segment_fill         = '0;
      next_segment         = '0;
      file_open            = 1'b0;
      file_run_no          = '0;
      file_segment_no      = '0;
   endtask

   task automatic account_packet(input item_type it);
      result_type            r;
      logic [DataWidth-1:0]  bytes;
      logic [DataWidth-1:0]  run_no;
      logic [DataWidth-1:0]  gap;
      logic [DataWidth-1:0]  span;
      logic [EventWidth-1:0] payload;
      bit                    is_end;
      r = '0;
      is_end = 1'b0;
      bytes = {16'd0, it.word_count, 2'b00};
      frame_byte_sum += bytes;
      frame_packets += 32'd1;
      if (it.marker_word == cfg_start_marker) begin
         frame_first_counter = it.counter_word;
         frame_no = it.frame_word;
         next_segment = '0;
         segment_fill = '0;
         run_no = it.frame_word;
         in_frame = 1'b1;
         payload = 16'(it.word_count) - 16'd4;
      end else begin
         r.no_start_error = !in_frame;
         is_end = (it.tail_word == cfg_end_marker);
         payload = 16'(it.word_count) - (is_end ? 16'd4 : 16'd2);
         run_no = it.buffer_run;
      end
      if (!file_open) begin
         file_open = 1'b1;
         file_run_no = run_no;
         file_segment_no = next_segment;
      end
      r.file_run = file_run_no;
      r.segment_index = file_segment_no;
      segment_fill += 64'(bytes);
      if (((segment_fill + 64'(SegPad)) >> MbShift) > 64'(cfg_segment_limit)) begin
         r.segment_closed = 1'b1;
         next_segment += 32'd1;
         segment_fill = '0;
         file_run_no = run_no;
         file_segment_no = next_segment;
      end
      frame_events += payload >> 1;
      if (is_end) begin
         r.frame_done = 1'b1;
         file_open = 1'b0;
         next_segment = '0;
         segment_fill = '0;
         if (!awaiting_first_frame) begin
            gap = frame_no - last_frame_no;
            if (gap != 32'd1) r.frames_lost = gap - 32'd1;
         end else begin
            awaiting_first_frame = 1'b0;
         end
         last_frame_no = frame_no;
         span = it.counter_word - (frame_first_counter - 32'd1);
         r.frame_number = frame_no;
         r.packet_total = frame_packets;
         r.event_total = frame_events;
         r.lost_events = it.lost_word[15:0];
         r.missed_packets = span - frame_packets;
         r.frame_bytes = frame_byte_sum;
         frame_byte_sum = '0;
         frame_packets = '0;
         frame_events = '0;
         in_frame = 1'b0;
      end
      packet_reports.push_back(r);
   endtask

   task automatic send_packet(input item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 2);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_ready !== 1'b1);
      account_packet(it);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (packet_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_config(input logic [31:0] start_value, input logic [31:0] end_value,
                              input logic [31:0] limit_value);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_START_MARKER;
      csr_write_data <= start_value;
      @(negedge clock);
      csr_index <= CSR_END_MARKER;
      csr_write_data <= end_value;
      @(negedge clock);
      csr_index <= CSR_SEGMENT_LIMIT;
      csr_write_data <= limit_value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cfg_start_marker = start_value;
      cfg_end_marker = end_value;
      cfg_segment_limit = limit_value[LimitWidth-1:0];
   endtask

   function automatic item_type item_of(input logic [13:0] word_count,
                                        input logic [31:0] counter, input logic [31:0] marker,
                                        input logic [31:0] frame, input logic [31:0] tail,
                                        input logic [31:0] lost, input logic [31:0] run_no);
      item_type it;
      it.word_count = word_count;
      it.counter_word = counter;
      it.marker_word = marker;
      it.frame_word = frame;
      it.tail_word = tail;
      it.lost_word = lost;
      it.buffer_run = run_no;
      return it;
   endfunction

   function automatic logic [13:0] pick_word_count(input bit big);
      int roll;
      roll = $urandom_range(0, 99);
      if (big && roll < 75) return 14'h3FFF;
      if (roll < 60) return 14'($urandom_range(4, 40));
      if (roll < 88) return 14'($urandom_range(4, 16383));
      return (roll < 94) ? 14'd4 : 14'h3FFF;
   endfunction

   function automatic item_type make_plain(input logic [31:0] counter, input bit big);
      item_type it;
      it = item_of(pick_word_count(big), counter, $urandom, $urandom, $urandom, $urandom,
                   $urandom);
      while (it.marker_word == cfg_start_marker) it.marker_word = $urandom;
      while (it.tail_word == cfg_end_marker) it.tail_word = $urandom;
      return it;
   endfunction

   function automatic item_type make_start(input logic [31:0] counter,
                                           input logic [31:0] frame, input bit big);
      item_type it;
      it = make_plain(counter, big);
      it.marker_word = cfg_start_marker;
      it.frame_word = frame;
      return it;
   endfunction

   function automatic item_type make_end(input logic [31:0] counter, input bit big);
      item_type it;
      it = make_plain(counter, big);
      it.tail_word = cfg_end_marker;
      return it;
   endfunction

   task automatic send_frame(input bit big, input bit with_end);
      int mids;
      int roll;
      mids = big ? $urandom_range(20, 40) : $urandom_range(0, 10);
      roll = $urandom_range(0, 9);
      if (roll < 7) gen_frame_no += 32'd1;
      else if (roll < 9) gen_frame_no = $urandom;
      send_packet(make_start(gen_counter, gen_frame_no, big));
      gen_counter += 32'd1;
      repeat (mids) begin
         if ($urandom_range(0, 19) == 0) gen_counter += $urandom_range(1, 1000);
         send_packet(make_plain(gen_counter, big));
         gen_counter += 32'd1;
      end
      if (with_end) begin
         send_packet(make_end(gen_counter, big));
         gen_counter += 32'd1;
      end
   endtask

   task automatic send_noise();
      item_type it;
      case ($urandom_range(0, 4))
         0: send_packet(make_plain($urandom, 1'b0));
         1: send_packet(make_end($urandom, 1'b0));
         2: send_frame(1'b0, 1'b0);
         3: begin
            it = item_of(14'($urandom_range(4, 16383)), $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
            send_packet(it);
         end
         default: begin
            it = make_end(gen_counter, 1'b0);
            it.marker_word = cfg_start_marker;
            send_packet(it);
         end
      endcase
   endtask

   task automatic run_traffic(input int item_goal, input int noise_pct);
      int first_item;
      first_item = items_sent;
      while (items_sent - first_item < item_goal) begin
         if ($urandom_range(0, 99) < noise_pct) send_noise();
         else send_frame($urandom_range(0, 9) == 0, 1'b1);
         // hold until the block has drained
         if ($urandom_range(0, 29) == 0) wait_for_results();
      end
   endtask

   task automatic test_reset_defaults();
      send_packet(item_of(14'd4, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0));
      send_packet(item_of(14'h3FFF, '1, '1, '1, '1, '1, '1));
      send_packet(item_of(14'd4, 32'd100, 32'd0, 32'd5, 32'd0, 32'h0000_1234, 32'd9));
      send_packet(item_of(14'd5, 32'd200, 32'd0, 32'd7, 32'h5555_AAAA, 32'd1, 32'd10));
      send_packet(item_of(14'd6, 32'd210, 32'd2, 32'd0, 32'd0, 32'hFFFF_ABCD, 32'd11));
   endtask

   task automatic test_segment_rollover();
      load_config('1, '1, 32'hFFFF_0000);
      send_packet(item_of(14'h3FFF, 32'd1000, '1, 32'd8, 32'd0, 32'd0, $urandom));
      for (int i = 1; i <= 15; i++)
         send_packet(item_of(14'h3FFF, 32'd1000 + i, 32'd0, $urandom, 32'd0, $urandom,
                             $urandom));
      send_packet(item_of(14'h3FFF, 32'd1016, 32'd0, 32'd0, '1, 32'h0001_0005, 32'h1234));
      send_packet(item_of(14'd4, 32'd5000, '1, 32'd3, 32'd0, 32'd0, 32'd77));
      send_packet(item_of(14'd5, 32'd5003, 32'd0, 32'd0, '1, 32'd0, 32'd78));
   endtask

   task automatic test_frame_traffic();
      load_config($urandom, $urandom, $urandom & 32'hFFFF_0000);
      run_traffic(450, 10);
   endtask

   task automatic test_segment_limits();
      load_config(32'd0, '1, 32'd1);
      run_traffic(350, 10);
      load_config($urandom, $urandom, 32'h0000_FFFF);
      run_traffic(350, 10);
      load_config($urandom, $urandom, ($urandom & 32'hFFFF_0000) | $urandom_range(2, 4));
      run_traffic(350, 10);
   endtask

   task automatic test_broken_sequences();
      load_config('1, 32'd0, $urandom_range(0, 2));
      run_traffic(400, 60);
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (packet_reports.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual file_run %h", $time,
                     rsp_file_run);
            error_count++;
         end else begin
            want = packet_reports.pop_front();
            check_field("file_run", want.file_run, rsp_file_run);
            check_field("segment_index", want.segment_index, rsp_segment_index);
            check_field("segment_closed", 32'(want.segment_closed), 32'(rsp_segment_closed));
            check_field("frame_done", 32'(want.frame_done), 32'(rsp_frame_done));
            check_field("no_start_error", 32'(want.no_start_error), 32'(rsp_no_start_error));
            check_field("frame_number", want.frame_number, rsp_frame_number);
            check_field("packet_total", want.packet_total, rsp_packet_total);
            check_field("event_total", 32'(want.event_total), 32'(rsp_event_total));
            check_field("lost_events", 32'(want.lost_events), 32'(rsp_lost_events));
            check_field("missed_packets", want.missed_packets, rsp_missed_packets);
            check_field("frames_lost", want.frames_lost, rsp_frames_lost);
            check_field("frame_bytes", want.frame_bytes, rsp_frame_bytes);
         end
      end
   end

   always @(negedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_phase_left = $urandom_range(16, 256);
      end else begin
         stall_phase_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (stall_phase_left % 6) < 2;
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_model();
      gen_counter = $urandom;
      gen_frame_no = $urandom;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_segment_rollover();
      test_frame_traffic();
      test_segment_limits();
      test_broken_sequences();
      wait_for_results();
      repeat (8) @(negedge clock);
      if (error_count == 0 && packet_reports.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
